>>> rtl/rcdbus_pkg.sv
`timescale 1ns / 1ps

package rcdbus_pkg;

    localparam int FRAME_LEN    = 17;
    localparam int KEPT_BYTES   = 6;
    localparam int NUM_CHANNELS = 6;
    localparam int NUM_STICKS   = 4;

    localparam int IDX_W      = 5;
    localparam int BSEL_W     = 3;
    localparam int CHAN_W     = 3;
    localparam int STEP_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 8;
    localparam int STICK_W    = 11;
    localparam int SWITCH_W   = 2;
    localparam int MASK_W     = 6;
    localparam int CH_W       = 11;
    localparam int QUOT_W     = 10;
    localparam int PROD_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 112;

    localparam logic [CH_W-1:0]     SCALE_FULL = 11'd1000;
    localparam logic [STEP_W-1:0]   STEP_LAST  = 4'(QUOT_W - 1);
    localparam logic [CHAN_W-1:0]   CHAN_LAST  = 3'(NUM_CHANNELS - 1);

    localparam logic [STICK_W-1:0]  RST_STICK_MIN  = 11'd364;
    localparam logic [STICK_W-1:0]  RST_STICK_MAX  = 11'd1684;
    localparam logic [SWITCH_W-1:0] RST_SWITCH_MIN = 2'd1;
    localparam logic [SWITCH_W-1:0] RST_SWITCH_MAX = 2'd3;
    localparam logic [MASK_W-1:0]   RST_INVERT     = 6'd2;
    localparam logic [GAP_W-1:0]    RST_GAP_LIMIT  = 8'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_MIN  = 3'd0,
        CFG_STICK_MAX  = 3'd1,
        CFG_SWITCH_MIN = 3'd2,
        CFG_SWITCH_MAX = 3'd3,
        CFG_INVERT     = 3'd4,
        CFG_GAP_LIMIT  = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_STORE = 5'b01000,
        ST_OUT   = 5'b10000
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic chan_load;
        logic div_step;
        logic chan_store;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic frame_end;
        logic step_last;
        logic chan_last;
    } ctrl_status_t;

endpackage

>>> rtl/rc_dbus_frame_decoder.sv
`timescale 1ns / 1ps

// Remote-control serial frame decoder. Each request on the s_ side is one received
// byte with its millisecond timestamp, and each one gives exactly one result on the
// m_ side. A gap above gap_limit_ms restarts the frame; the byte that completes a
// frame sets m_tuser and carries six freshly scaled channels (0..1000, negated per
// invert_mask), the frame count and the gap before that byte; other bytes repeat the
// last channels with a zero gap. A byte that does not end a frame loads its result
// on acceptance. On a frame-ending byte, each channel passes through one shared
// restoring divider (a load step, ten quotient steps, a store step), then the result
// is placed once the output register is free; no byte is taken meanwhile. A waiting
// result blocks no byte if the output register is free or drained in the same cycle.
module rc_dbus_frame_decoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // rx_byte[7:0], now_ms[39:8]
    input  logic [rcdbus_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // stick_a[10:0], stick_b[21:11], stick_c[32:22], stick_d[43:33],
    // switch_left[54:44], switch_right[65:55], frames_seen[97:66],
    // sync_gap_ms[105:98], zero fill[111:106]
    output logic [rcdbus_pkg::OUT_DATA_W-1:0]     m_tdata,
    // frame_done[0]
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [rcdbus_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcdbus_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rcdbus_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    rcdbus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcdbus_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> rtl/rcdbus_ctrl.sv
`timescale 1ns / 1ps

module rcdbus_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  rcdbus_pkg::ctrl_status_t status,
    output rcdbus_pkg::ctrl_cmd_t    cmd
);
    import rcdbus_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
                if (cmd.accept && status.frame_end) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.chan_load = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.chan_store = 1'b1;
                state_next     = status.chan_last ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rcdbus_datapath.sv
`timescale 1ns / 1ps

module rcdbus_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [rcdbus_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [rcdbus_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [rcdbus_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcdbus_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  rcdbus_pkg::ctrl_cmd_t                 cmd,
    output rcdbus_pkg::ctrl_status_t              status
);
    import rcdbus_pkg::*;

    // configuration
    logic [STICK_W-1:0]  stick_min_reg, stick_max_reg;
    logic [SWITCH_W-1:0] switch_min_reg, switch_max_reg;
    logic [MASK_W-1:0]   invert_reg;
    logic [GAP_W-1:0]    gap_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_min_reg  <= RST_STICK_MIN;
            stick_max_reg  <= RST_STICK_MAX;
            switch_min_reg <= RST_SWITCH_MIN;
            switch_max_reg <= RST_SWITCH_MAX;
            invert_reg     <= RST_INVERT;
            gap_limit_reg  <= RST_GAP_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STICK_MIN:  stick_min_reg  <= cfg_wdata;
                CFG_STICK_MAX:  stick_max_reg  <= cfg_wdata;
                CFG_SWITCH_MIN: switch_min_reg <= cfg_wdata[SWITCH_W-1:0];
                CFG_SWITCH_MAX: switch_max_reg <= cfg_wdata[SWITCH_W-1:0];
                CFG_INVERT:     invert_reg     <= cfg_wdata[MASK_W-1:0];
                CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_wdata[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte framing
    logic [BYTE_W-1:0] byte_in;
    logic [TIME_W-1:0] now_in, gap;
    logic [IDX_W-1:0]  idx_reg, idx_eff, idx_inc;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] frames_reg;
    logic [GAP_W-1:0]  sync_reg;
    logic [BYTE_W-1:0] frame_bytes_reg [KEPT_BYTES];
    logic              frame_end;

    assign byte_in   = s_tdata[BYTE_W-1:0];
    assign now_in    = s_tdata[BYTE_W +: TIME_W];
    assign gap       = now_in - last_time_reg;
    assign idx_eff   = (gap > TIME_W'(gap_limit_reg)) ? '0 : idx_reg;
    assign idx_inc   = idx_eff + 5'd1;
    assign frame_end = (idx_inc == IDX_W'(FRAME_LEN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            last_time_reg <= '0;
            frames_reg    <= '0;
        end else if (cmd.accept) begin
            idx_reg       <= frame_end ? '0 : idx_inc;
            last_time_reg <= now_in;
            if (frame_end) begin
                frames_reg <= frames_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (idx_eff < IDX_W'(KEPT_BYTES)) begin
                frame_bytes_reg[idx_eff[BSEL_W-1:0]] <= byte_in;
            end
            sync_reg <= gap[GAP_W-1:0];
        end
    end

    // channel unpack and scaling, one channel at a time through a shared divider
    logic [CHAN_W-1:0]  chan_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CH_W-1:0]    raw, lo, hi, diff, span;
    logic [PROD_W-1:0]  prod;
    logic [CH_W-1:0]    den_reg, rem_reg, rem_sub;
    logic [QUOT_W-1:0]  low_reg;
    logic [CH_W:0]      trial;
    logic               trial_ge;
    logic               zero_reg, full_reg;
    logic [CH_W-1:0]    quot, scaled;
    logic [CH_W-1:0]    held_reg [NUM_CHANNELS];

    always_comb begin
        case (chan_reg)
            3'd0: raw = {frame_bytes_reg[1][2:0], frame_bytes_reg[0]};
            3'd1: raw = {frame_bytes_reg[2][5:0], frame_bytes_reg[1][7:3]};
            3'd2: raw = {frame_bytes_reg[5][3:0], frame_bytes_reg[4][7:1]};
            3'd3: raw = {frame_bytes_reg[4][0], frame_bytes_reg[3], frame_bytes_reg[2][7:6]};
            3'd4: raw = {9'd0, frame_bytes_reg[5][7:6]};
            3'd5: raw = {9'd0, frame_bytes_reg[5][5:4]};
            default: raw = '0;
        endcase
    end

    assign lo   = (chan_reg < CHAN_W'(NUM_STICKS)) ? stick_min_reg : CH_W'(switch_min_reg);
    assign hi   = (chan_reg < CHAN_W'(NUM_STICKS)) ? stick_max_reg : CH_W'(switch_max_reg);
    assign diff = raw - lo;
    assign span = hi - lo;
    // quotient below 1000 when raw < hi, so product < span * 2^10
    assign prod = PROD_W'(diff) * PROD_W'(SCALE_FULL);

    assign trial    = {rem_reg, low_reg[QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign rem_sub  = CH_W'(trial - {1'b0, den_reg});

    assign quot   = zero_reg ? '0 : (full_reg ? SCALE_FULL : CH_W'(low_reg));
    assign scaled = invert_reg[chan_reg] ? CH_W'(~quot + 11'd1) : quot;

    always_ff @(posedge aclk) begin
        if (cmd.chan_load) begin
            den_reg  <= span;
            rem_reg  <= prod[PROD_W-1:QUOT_W];
            low_reg  <= prod[QUOT_W-1:0];
            zero_reg <= (hi <= lo) || (raw <= lo);
            full_reg <= (raw >= hi);
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? rem_sub : trial[CH_W-1:0];
            low_reg <= {low_reg[QUOT_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
            step_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            if (cmd.chan_load) begin
                step_reg <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + 4'd1;
            end
            if (cmd.chan_store) begin
                held_reg[chan_reg] <= scaled;
                chan_reg <= (chan_reg == CHAN_LAST) ? '0 : chan_reg + 3'd1;
            end
        end
    end

    // output register
    logic                  m_tvalid_reg;
    logic                  done_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [GAP_W-1:0]      out_sync;
    logic                  load_out;

    assign load_out = (cmd.accept && !frame_end) || cmd.out_load;
    assign out_sync = cmd.out_load ? sync_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            done_reg   <= cmd.out_load;
            m_data_reg <= {6'd0, out_sync, frames_reg,
                           held_reg[5], held_reg[4], held_reg[3],
                           held_reg[2], held_reg[1], held_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = done_reg;

    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.frame_end = frame_end;
    assign status.step_last = (step_reg == STEP_LAST);
    assign status.chan_last = (chan_reg == CHAN_LAST);

endmodule

>>> rtl/rcdbus_checker.sv
`timescale 1ns / 1ps

module rcdbus_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [rcdbus_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                  m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // output register clears on reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new byte is taken only when the pending result drains in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tready)
        else $error("input ready while output register is blocked");

    // gap is reported only on a completed frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[105:98] == 8'd0)
        else $error("nonzero gap without frame end");

    // a request either gives its result next cycle or holds off the input while scaling
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("request accepted while a frame is being scaled");

endmodule

bind rc_dbus_frame_decoder rcdbus_checker u_rcdbus_checker (.*);

>>> bench/rc_dbus_frame_decoder_tb.sv
`timescale 1ns / 1ps

module rc_dbus_frame_decoder_tb;
    import rcdbus_pkg::*;

    localparam int COUNT_LSB   = NUM_CHANNELS * CH_W;
    localparam int SYNC_LSB    = COUNT_LSB + TIME_W;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 240;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct {
        logic              frame_done;
        logic [CH_W-1:0]   chan [NUM_CHANNELS];
        logic [TIME_W-1:0] count;
        logic [GAP_W-1:0]  sync_gap;
    } dbus_result_t;

    typedef enum {RX_OPEN, RX_COIN, RX_HOLD} rx_mode_t;

    // decoder shadow: config, frame state and the results still owed by the block
    class dbus_checker;
        logic [STICK_W-1:0]  stick_lo;
        logic [STICK_W-1:0]  stick_hi;
        logic [SWITCH_W-1:0] switch_lo;
        logic [SWITCH_W-1:0] switch_hi;
        logic [MASK_W-1:0]   invert;
        logic [GAP_W-1:0]    gap_limit;
        logic [IDX_W-1:0]    byte_pos;
        logic [TIME_W-1:0]   prev_ms;
        logic [BYTE_W-1:0]   kept [KEPT_BYTES];
        logic [TIME_W-1:0]   frame_count;
        logic [CH_W-1:0]     held [NUM_CHANNELS];
        dbus_result_t        due_results[$];
        string               chan_name [NUM_CHANNELS];
        int                  fails;

        function new();
            stick_lo    = RST_STICK_MIN;
            stick_hi    = RST_STICK_MAX;
            switch_lo   = RST_SWITCH_MIN;
            switch_hi   = RST_SWITCH_MAX;
            invert      = RST_INVERT;
            gap_limit   = RST_GAP_LIMIT;
            byte_pos    = '0;
            prev_ms     = '0;
            frame_count = '0;
            fails       = 0;
            foreach (kept[i]) kept[i] = '0;
            foreach (held[i]) held[i] = '0;
            chan_name = '{"stick_a", "stick_b", "stick_c", "stick_d",
                          "switch_left", "switch_right"};
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STICK_MIN:  stick_lo  = data[STICK_W-1:0];
                CFG_STICK_MAX:  stick_hi  = data[STICK_W-1:0];
                CFG_SWITCH_MIN: switch_lo = data[SWITCH_W-1:0];
                CFG_SWITCH_MAX: switch_hi = data[SWITCH_W-1:0];
                CFG_INVERT:     invert    = data[MASK_W-1:0];
                CFG_GAP_LIMIT:  gap_limit = data[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CH_W-1:0] scaled(input logic [CH_W-1:0] raw, lo, hi,
                                         input logic neg);
            logic [31:0] q;
            q = '0;
            if (hi > lo && raw > lo) begin
                q = (32'(raw - lo) * 32'd1000) / 32'(hi - lo);
                if (q > 32'd1000) q = 32'd1000;
            end
            if (neg) q = -q;
            return q[CH_W-1:0];
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
            logic [TIME_W-1:0] gap;
            logic [CH_W-1:0]   raw [NUM_CHANNELS];
            dbus_result_t      r;
            gap = t - prev_ms;
            if (gap > 32'(gap_limit)) byte_pos = '0;
            if (byte_pos < KEPT_BYTES) kept[byte_pos] = b;
            byte_pos = byte_pos + 1'b1;
            r.frame_done = 1'b0;
            r.sync_gap   = '0;
            if (byte_pos == FRAME_LEN) begin
                raw[0] = {kept[1][2:0], kept[0]};
                raw[1] = {kept[2][5:0], kept[1][7:3]};
                raw[2] = {kept[5][3:0], kept[4][7:1]};
                raw[3] = {kept[4][0], kept[3], kept[2][7:6]};
                raw[4] = 11'(kept[5][7:6]);
                raw[5] = 11'(kept[5][5:4]);
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (i < NUM_STICKS)
                        held[i] = scaled(raw[i], stick_lo, stick_hi, invert[i]);
                    else
                        held[i] = scaled(raw[i], 11'(switch_lo), 11'(switch_hi), invert[i]);
                end
                frame_count  = frame_count + 1'b1;
                r.frame_done = 1'b1;
                r.sync_gap   = gap[GAP_W-1:0];
                byte_pos     = '0;
            end
            prev_ms = t;
            r.chan  = held;
            r.count = frame_count;
            due_results.push_back(r);
        endfunction

        function void match_result(input logic done, input logic [OUT_DATA_W-1:0] data);
            dbus_result_t    want;
            logic [CH_W-1:0] got;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
                return;
            end
            want = due_results.pop_front();
            if (done !== want.frame_done) begin
                $error("frame_done: expected %0d, got %0d", want.frame_done, done);
                fails++;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                got = data[i*CH_W +: CH_W];
                if (got !== want.chan[i]) begin
                    $error("%s: expected %0d, got %0d", chan_name[i],
                           $signed(want.chan[i]), $signed(got));
                    fails++;
                end
            end
            if (data[COUNT_LSB +: TIME_W] !== want.count) begin
                $error("frames_seen: expected %0d, got %0d", want.count,
                       data[COUNT_LSB +: TIME_W]);
                fails++;
            end
            if (data[SYNC_LSB +: GAP_W] !== want.sync_gap) begin
                $error("sync_gap_ms: expected %0d, got %0d", want.sync_gap,
                       data[SYNC_LSB +: GAP_W]);
                fails++;
            end
        endfunction

        function int owed();
            return due_results.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tuser;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    dbus_checker       sb;
    logic [TIME_W-1:0] clock_ms;
    int                burst_left;
    bit                tx_steady;
    int                idle_cycles = 0;
    rx_mode_t          rx_mode = RX_OPEN;
    logic [7:0]        rx_tick = '0;
    int                rx_hold = 0;

    always #6 aclk = ~aclk;

    rc_dbus_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // receiver: open, coin-flip or occasional long stalls, mode redrawn when the 8-bit tick wraps
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(1, 20);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.match_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** rc_dbus_frame_decoder: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [TIME_W-1:0] in_frame_gap();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'(sb.gap_limit);
            default: return 32'($urandom_range(0, sb.gap_limit));
        endcase
    endfunction

    // a gap long enough to restart the frame, now and then a jump to any timestamp
    function automatic logic [TIME_W-1:0] break_gap();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'(sb.gap_limit) + 32'd1 + 32'($urandom_range(0, 300));
    endfunction

    // called and returns on a falling edge
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
        int idle;
        if (burst_left == 0) begin
            idle = tx_steady ? 0 : $urandom_range(0, 8);
            if (idle != 0) begin
                s_tvalid = 1'b0;
                repeat (idle) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tdata  = {t, b};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, t);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_after(input logic [TIME_W-1:0] delta, input logic [BYTE_W-1:0] b);
        clock_ms = clock_ms + delta;
        push_byte(b, clock_ms);
    endtask

    // len below FRAME_LEN leaves a broken frame behind
    task automatic send_frame(input int len);
        for (int k = 0; k < len; k++) begin
            if (k == 0 && (sb.byte_pos != 0 || $urandom_range(0, 1) == 0))
                send_after(break_gap(), 8'($urandom));
            else
                send_after(in_frame_gap(), 8'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (sb.owed() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic setup_phase(input int phase);
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] w;
        case (phase)
            1: begin
                // widest spans, everything inverted, longest gap tolerance
                write_cfg(CFG_STICK_MIN, 11'd0);
                write_cfg(CFG_STICK_MAX, 11'd2047);
                write_cfg(CFG_SWITCH_MIN, 11'd0);
                write_cfg(CFG_SWITCH_MAX, 11'd3);
                write_cfg(CFG_INVERT, 11'h03F);
                write_cfg(CFG_GAP_LIMIT, 11'd255);
            end
            2: begin
                // negative spans, bytes must arrive in the same ms
                write_cfg(CFG_STICK_MIN, 11'd2047);
                write_cfg(CFG_STICK_MAX, 11'd0);
                write_cfg(CFG_SWITCH_MIN, 11'd3);
                write_cfg(CFG_SWITCH_MAX, 11'd0);
                write_cfg(CFG_INVERT, 11'd0);
                write_cfg(CFG_GAP_LIMIT, 11'd0);
            end
            3: begin
                // zero spans, plus writes to the unused indices
                v = 11'($urandom_range(0, 2047));
                w = 11'($urandom_range(0, 3));
                write_cfg(CFG_STICK_MIN, v);
                write_cfg(CFG_STICK_MAX, v);
                write_cfg(CFG_SWITCH_MIN, w);
                write_cfg(CFG_SWITCH_MAX, w);
                write_cfg(CFG_INVERT, 11'($urandom));
                write_cfg(CFG_GAP_LIMIT, 11'd1);
                for (int k = int'(CFG_GAP_LIMIT) + 1; k < (1 << CFG_IDX_W); k++)
                    write_cfg(CFG_IDX_W'(k), 11'($urandom));
            end
            default: begin
                write_cfg(CFG_STICK_MIN, 11'($urandom));
                write_cfg(CFG_STICK_MAX, 11'($urandom));
                write_cfg(CFG_SWITCH_MIN, 11'($urandom));
                write_cfg(CFG_SWITCH_MAX, 11'($urandom));
                write_cfg(CFG_INVERT, 11'($urandom));
                write_cfg(CFG_GAP_LIMIT, 11'($urandom));
            end
        endcase
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        int sent;
        int pick;
        logic [BYTE_W-1:0] head [KEPT_BYTES];
        sb         = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_STICK_MIN;
        cfg_wdata  = '0;
        clock_ms   = 32'd3;
        burst_left = 0;
        tx_steady  = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // stray bytes right after reset, then a restart and a frame across the ms wrap
        send_after(32'd0, 8'h00);
        send_after(32'd1, 8'hFF);
        send_after(32'd1, 8'h5A);
        clock_ms = 32'hFFFF_FFF8;
        // stick_a below min, stick_b/stick_d saturate, stick_c low, switches at min and max
        head = '{8'h00, 8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h70};
        push_byte(head[0], clock_ms);
        for (int k = 1; k < FRAME_LEN; k++) begin
            if (k < KEPT_BYTES)
                send_after(32'd1, head[k]);
            else
                send_after((k == FRAME_LEN - 1) ? 32'(sb.gap_limit) : 32'(k % 2),
                           (k % 2 == 0) ? 8'hFF : 8'h00);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                setup_phase(phase);
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    send_frame(FRAME_LEN);
                    sent += FRAME_LEN;
                end else if (pick < 17) begin
                    pick = $urandom_range(1, FRAME_LEN - 1);
                    send_frame(pick);
                    sent += pick;
                end else begin
                    pick = $urandom_range(1, 4);
                    for (int k = 0; k < pick; k++)
                        send_after(32'($urandom_range(0, 2 * sb.gap_limit + 2)), 8'($urandom));
                    sent += pick;
                end
            end
        end

        s_tvalid = 1'b0;
        while (sb.owed() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (sb.fails == 0)
            $display("** rc_dbus_frame_decoder: PASSED **");
        else
            $display("** rc_dbus_frame_decoder: FAILED **");
        $finish;
    end

endmodule
